>>> sv/mbad_pkg.sv
`timescale 1ns / 1ps
// Package for the Modbus ASCII frame decoder: character codes, status codes,
// frame limits and the token type that the front part hands to the back part.
// No dependencies.
package mbad_pkg;

	localparam int MAX_BYTES = 256;
	localparam int MIN_BYTES = 3;
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_F     = 8'h46;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_LRC    = 3'd1,
		ST_SHORT  = 3'd2,
		ST_FORMAT = 3'd3,
		ST_LONG   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		TK_START  = 2'd0,
		TK_NIBBLE = 2'd1,
		TK_BAD    = 2'd2,
		TK_END    = 2'd3
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [3:0] nib;
	} token_t;

	// Word passed between the parts together with its valid flag; ready runs
	// beside it as a separate signal.
	typedef struct packed {
		logic   valid;
		token_t tok;
	} tok_word_t;

endpackage

>>> sv/mbad_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the received character and the decoded
// result word. Depends on nothing.
interface mbad_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_char;

	modport source (output valid, output rx_char, input ready);
	modport sink   (input valid, input rx_char, output ready);
endinterface

interface mbad_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_address;
	logic       frame_end;
	logic [2:0] status;
	logic [7:0] pdu_length;

	modport source (output valid, output data_byte, output is_address, output frame_end,
		output status, output pdu_length, input ready);
	modport sink   (input valid, input data_byte, input is_address, input frame_end,
		input status, input pdu_length, output ready);
endinterface

>>> sv/mbad_front.sv
`timescale 1ns / 1ps
// Front part: accepts characters, tracks whether a frame is open and turns
// each relevant character into a token. Depends on mbad_pkg and mbad_if.
module mbad_front import mbad_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	mbad_char_if.sink       rx,
	input  logic            push_ready,
	output tok_word_t       push
);

	logic       in_frame_q;
	logic [7:0] c;
	logic       acc;
	token_t     tok;
	logic       keep;

	assign c        = rx.rx_char;
	assign rx.ready = push_ready;
	assign acc      = rx.valid && push_ready;

	always_comb begin
		tok.nib = 4'd0;
		keep    = 1'b0;
		if (c == CH_COLON) begin
			tok.kind = TK_START;
			keep     = 1'b1;
		end else if (c == CH_LF) begin
			tok.kind = TK_END;
			keep     = in_frame_q;
		end else if (c inside {[CH_0:CH_9]}) begin
			tok.kind = TK_NIBBLE;
			tok.nib  = c[3:0];
			keep     = in_frame_q;
		end else if (c inside {[CH_A:CH_F]}) begin
			tok.kind = TK_NIBBLE;
			tok.nib  = 4'(c - CH_A + 8'd10);
			keep     = in_frame_q;
		end else begin
			// Carriage return changes nothing; anything else inside a frame is a fault.
			tok.kind = TK_BAD;
			keep     = in_frame_q && (c != CH_CR);
		end
	end

	assign push.valid = acc && keep;
	assign push.tok   = tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (acc) begin
			if (c == CH_COLON) begin
				in_frame_q <= 1'b1;
			end else if (c == CH_LF) begin
				in_frame_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/mbad_queue.sv
`timescale 1ns / 1ps
// Short token queue between the front and back parts.
// Depends on mbad_pkg.
module mbad_queue import mbad_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tok_word_t push,
	output logic      push_ready,
	output tok_word_t pop,
	input  logic      pop_ready
);

	token_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (cnt_q != Q_CNT_W'(Q_DEPTH));
	assign pop.valid  = (cnt_q != '0);
	assign pop.tok    = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop.valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/mbad_back.sv
`timescale 1ns / 1ps
// Back part: pairs nibbles into bytes, keeps the LRC sum and byte count,
// delays bytes by one and drives the registered result channel.
// Depends on mbad_pkg and mbad_if.
module mbad_back import mbad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tok_word_t   pop,
	output logic        pop_ready,
	mbad_res_if.source  dec
);

	logic             half_q;
	logic [3:0]       upper_q;
	logic [7:0]       held_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       sum_q;
	logic             ferr_q;
	logic             lerr_q;

	logic             out_valid_q;
	logic [7:0]       data_q;
	logic             addr_q;
	logic             end_q;
	status_t          status_q;
	logic [7:0]       plen_q;

	logic             take;
	logic [7:0]       byte_w;
	logic             full;
	status_t          st_w;

	assign pop_ready = !out_valid_q || dec.ready;
	assign take      = pop.valid && pop_ready;
	assign byte_w    = {upper_q, pop.tok.nib};
	assign full      = (cnt_q >= CNT_W'(MAX_BYTES));

	always_comb begin
		if (ferr_q || half_q) begin
			st_w = ST_FORMAT;
		end else if (lerr_q) begin
			st_w = ST_LONG;
		end else if (cnt_q < CNT_W'(MIN_BYTES)) begin
			st_w = ST_SHORT;
		end else if (sum_q != 8'd0) begin
			st_w = ST_LRC;
		end else begin
			st_w = ST_OK;
		end
	end

	assign dec.valid      = out_valid_q;
	assign dec.data_byte  = data_q;
	assign dec.is_address = addr_q;
	assign dec.frame_end  = end_q;
	assign dec.status     = status_q;
	assign dec.pdu_length = plen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= 1'b0;
			upper_q     <= 4'd0;
			held_q      <= 8'd0;
			cnt_q       <= '0;
			sum_q       <= 8'd0;
			ferr_q      <= 1'b0;
			lerr_q      <= 1'b0;
			out_valid_q <= 1'b0;
			data_q      <= 8'd0;
			addr_q      <= 1'b0;
			end_q       <= 1'b0;
			status_q    <= ST_OK;
			plen_q      <= 8'd0;
		end else if (take) begin
			// The old result, if any, leaves in this cycle.
			case (pop.tok.kind)
				TK_START: begin
					out_valid_q <= 1'b0;
					half_q      <= 1'b0;
					upper_q     <= 4'd0;
					held_q      <= 8'd0;
					cnt_q       <= '0;
					sum_q       <= 8'd0;
					ferr_q      <= 1'b0;
					lerr_q      <= 1'b0;
				end
				TK_BAD: begin
					out_valid_q <= 1'b0;
					ferr_q      <= 1'b1;
				end
				TK_NIBBLE: begin
					if (!half_q) begin
						out_valid_q <= 1'b0;
						upper_q     <= pop.tok.nib;
						half_q      <= 1'b1;
					end else begin
						half_q <= 1'b0;
						if (full) begin
							out_valid_q <= 1'b0;
							lerr_q      <= 1'b1;
						end else begin
							sum_q       <= sum_q + byte_w;
							held_q      <= byte_w;
							cnt_q       <= cnt_q + 1'b1;
							out_valid_q <= (cnt_q != '0);
							// The previous byte goes out now; the last one is the LRC.
							if (cnt_q != '0) begin
								data_q   <= held_q;
								addr_q   <= (cnt_q == CNT_W'(1));
								end_q    <= 1'b0;
								status_q <= ST_OK;
								plen_q   <= 8'd0;
							end
						end
					end
				end
				TK_END: begin
					out_valid_q <= 1'b1;
					data_q      <= 8'd0;
					addr_q      <= 1'b0;
					end_q       <= 1'b1;
					status_q    <= st_w;
					plen_q      <= (st_w == ST_OK) ? 8'(cnt_q - CNT_W'(2)) : 8'd0;
				end
				default: begin
					out_valid_q <= 1'b0;
				end
			endcase
		end else if (dec.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/modbus_ascii_frame_decoder.sv
`timescale 1ns / 1ps
// Modbus ASCII frame decoder. One received character is taken per cycle while
// the token queue has room; ':' opens a frame, upper-case hex pairs form bytes,
// CR is ignored and LF closes the frame with one status word (0 ok, 1 LRC
// mismatch, 2 too short, 3 bad or odd hex digit, 4 too long). Data bytes leave
// one byte late, so the trailing LRC is never emitted, and the first one is
// flagged as the address. Each character passes the classifier in its accepting
// cycle, waits in a four-entry token queue, and is retired by the frame logic,
// so the sustained rate is one character per cycle while nothing stalls; a token
// is registered in the queue and its result then in an output register, where it
// is held until taken, while input keeps flowing until the queue fills.
// Depends on mbad_pkg, mbad_if, mbad_front, mbad_queue and mbad_back.
module modbus_ascii_frame_decoder import mbad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mbad_char_if.sink   rx,
	mbad_res_if.source  dec
);

	tok_word_t push;
	tok_word_t pop;
	logic      push_ready;
	logic      pop_ready;

	mbad_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push_ready (push_ready),
		.push       (push)
	);

	mbad_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_ready  (pop_ready)
	);

	mbad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.pop_ready (pop_ready),
		.dec       (dec)
	);

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus ASCII frame decoder: a directed table
// followed by random frames, checked against a cycle-free frame predictor.
// Depends on mbad_pkg, mbad_if and modbus_ascii_frame_decoder.
module tb_top;
	import mbad_pkg::*;

	localparam int         ITEM_TARGET  = 1400;
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         DRAIN_CYCLES = 20;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_address;
		logic       frame_end;
		status_t    status;
		logic [7:0] pdu_length;
	} dec_word_t;

	typedef struct {
		logic [7:0] ch;
		bit         fixed;
		dec_word_t  want;
	} stim_row_t;

	localparam dec_word_t NO_WORD = '0;

	bit         clk;
	bit         arst_n;
	bit         chr_valid;
	bit [7:0]   chr_data;
	bit         res_ready;

	mbad_char_if rx_if();
	mbad_res_if  res_if();

	assign rx_if.valid   = chr_valid;
	assign rx_if.rx_char = chr_data;
	assign res_if.ready  = res_ready;

	modbus_ascii_frame_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if.sink),
		.dec    (res_if.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Frame state of the predictor.
	bit             fr_open;
	bit             nib_pending;
	logic [3:0]     hi_nib;
	logic [7:0]     held;
	logic [CNT_W-1:0] nbytes;
	logic [7:0]     sum;
	bit             fmt_bad;
	bit             len_bad;

	dec_word_t pending_words[$];
	stim_row_t dir_rows[];
	int        items_used;
	int        n_fail;
	int        idle_cycles;
	int        stall_left;
	bit        src_calm;
	bit        sink_calm;

	function automatic dec_word_t word_of(input logic [7:0] d, input logic a, input logic e,
		input status_t st, input logic [7:0] pl);
		dec_word_t w;
		w.data_byte  = d;
		w.is_address = a;
		w.frame_end  = e;
		w.status     = st;
		w.pdu_length = pl;
		return w;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'hA) ? CH_0 + 8'(v) : CH_A + 8'(v - 4'hA);
	endfunction

	// Mostly no gap, some short ones and a few long; now and then the side
	// switches into a calm stretch with no gaps at all.
	function automatic int pick_gap(inout bit calm);
		int r;
		if ($urandom_range(0, 199) == 0)
			calm = !calm;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Advances the frame state by one character; returns 1 with the word that
	// the character releases, if any.
	function automatic bit decode_char(input logic [7:0] ch, output dec_word_t w);
		logic [3:0] nib;
		logic [7:0] b;
		bit         got;
		w = NO_WORD;
		if (ch == CH_COLON) begin
			fr_open     = 1'b1;
			nib_pending = 1'b0;
			hi_nib      = '0;
			held        = '0;
			nbytes      = '0;
			sum         = '0;
			fmt_bad     = 1'b0;
			len_bad     = 1'b0;
			return 1'b0;
		end
		if (!fr_open || ch == CH_CR)
			return 1'b0;
		if (ch == CH_LF) begin
			fr_open     = 1'b0;
			w.frame_end = 1'b1;
			if (fmt_bad || nib_pending)
				w.status = ST_FORMAT;
			else if (len_bad)
				w.status = ST_LONG;
			else if (nbytes < MIN_BYTES)
				w.status = ST_SHORT;
			else if (sum != 8'h00)
				w.status = ST_LRC;
			else begin
				w.status     = ST_OK;
				w.pdu_length = 8'(nbytes - 2);
			end
			return 1'b1;
		end
		if (ch >= CH_0 && ch <= CH_9)
			nib = 4'(ch - CH_0);
		else if (ch >= CH_A && ch <= CH_F)
			nib = 4'(ch - CH_A + 8'h0A);
		else begin
			fmt_bad = 1'b1;
			return 1'b0;
		end
		if (!nib_pending) begin
			hi_nib      = nib;
			nib_pending = 1'b1;
			return 1'b0;
		end
		nib_pending = 1'b0;
		b = {hi_nib, nib};
		// A byte beyond the frame limit is dropped without touching the sum.
		if (nbytes >= MAX_BYTES) begin
			len_bad = 1'b1;
			return 1'b0;
		end
		sum = sum + b;
		got = (nbytes >= 1);
		if (got) begin
			w.data_byte  = held;
			w.is_address = (nbytes == 1);
		end
		held   = b;
		nbytes = nbytes + 1'b1;
		return got;
	endfunction

	task automatic put_char(input logic [7:0] ch, input bit fixed = 1'b0,
		input dec_word_t want = NO_WORD);
		dec_word_t w;
		int        gap;
		gap = pick_gap(src_calm);
		if (gap > 0) begin
			chr_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chr_valid <= 1'b1;
		chr_data  <= ch;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		if (fr_open || ch == CH_COLON)
			items_used++;
		if (decode_char(ch, w) && !fixed)
			pending_words.push_back(w);
		if (fixed)
			pending_words.push_back(want);
	endtask

	// One frame with pdu_n bytes after the address, usually well formed; some
	// get a wrong LRC, a stray character, a lost digit or a restart in front.
	task automatic send_frame(input int pdu_n);
		logic [7:0] line[$];
		logic [7:0] lrc;
		logic [7:0] b;
		int         sel;
		int         k;
		lrc = 8'h00;
		sel = $urandom_range(0, 99);
		line.push_back(CH_COLON);
		for (k = 0; k <= pdu_n; k++) begin
			b = 8'($urandom_range(0, 255));
			lrc = lrc - b;
			line.push_back(hex_char(b[7:4]));
			line.push_back(hex_char(b[3:0]));
		end
		if (sel >= 75 && sel < 82)
			lrc = lrc ^ 8'($urandom_range(1, 255));
		line.push_back(hex_char(lrc[7:4]));
		line.push_back(hex_char(lrc[3:0]));
		if (sel >= 82 && sel < 88) begin
			b = $urandom_range(0, 1) ? CH_LOWER_A + 8'($urandom_range(0, 5))
				: 8'($urandom_range(0, 255));
			line.insert($urandom_range(1, line.size()), b);
		end else if (sel >= 88 && sel < 92) begin
			line.delete($urandom_range(1, line.size() - 1));
		end else if (sel >= 92 && sel < 96) begin
			for (k = $urandom_range(0, 5); k > 0; k--)
				line.push_front(hex_char(4'($urandom_range(0, 15))));
			line.push_front(CH_COLON);
		end
		if ($urandom_range(0, 9) < 8)
			line.push_back(CH_CR);
		if ($urandom_range(0, 29) != 0)
			line.push_back(CH_LF);
		foreach (line[i])
			put_char(line[i]);
	endtask

	always @(posedge clk) begin
		dec_word_t exp_w;
		if (res_if.valid && res_if.ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected word: data_byte %02h, frame_end %0b, status %0d",
					res_if.data_byte, res_if.frame_end, res_if.status);
				n_fail++;
			end else begin
				exp_w = pending_words.pop_front();
				if (res_if.data_byte !== exp_w.data_byte) begin
					$error("data_byte: expected %02h, got %02h", exp_w.data_byte,
						res_if.data_byte);
					n_fail++;
				end
				if (res_if.is_address !== exp_w.is_address) begin
					$error("is_address: expected %0b, got %0b", exp_w.is_address,
						res_if.is_address);
					n_fail++;
				end
				if (res_if.frame_end !== exp_w.frame_end) begin
					$error("frame_end: expected %0b, got %0b", exp_w.frame_end,
						res_if.frame_end);
					n_fail++;
				end
				if (res_if.status !== 3'(exp_w.status)) begin
					$error("status: expected %0d, got %0d", exp_w.status, res_if.status);
					n_fail++;
				end
				if (res_if.pdu_length !== exp_w.pdu_length) begin
					$error("pdu_length: expected %0d, got %0d", exp_w.pdu_length,
						res_if.pdu_length);
					n_fail++;
				end
			end
		end
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (stall_left > 0) begin
			res_ready <= 1'b0;
			stall_left--;
		end else begin
			res_ready  <= 1'b1;
			stall_left = pick_gap(sink_calm);
		end
	end

	// Ends a hung run: no word moving on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int frame_no;
		int pdu_n;
		dir_rows = '{
			'{8'hFF, 1'b0, NO_WORD},
			'{CH_LF, 1'b0, NO_WORD},
			'{CH_COLON, 1'b0, NO_WORD},
			'{CH_F, 1'b0, NO_WORD},
			'{CH_F, 1'b0, NO_WORD},
			'{CH_0, 1'b0, NO_WORD},
			'{hex_char(4'h1), 1'b1, word_of(8'hFF, 1'b1, 1'b0, ST_OK, 8'd0)},
			'{CH_0, 1'b0, NO_WORD},
			'{CH_0, 1'b1, word_of(8'h01, 1'b0, 1'b0, ST_OK, 8'd0)},
			'{CH_CR, 1'b0, NO_WORD},
			'{CH_LF, 1'b1, word_of(8'h00, 1'b0, 1'b1, ST_OK, 8'd1)},
			// Lower-case digit followed by a lone digit.
			'{CH_COLON, 1'b0, NO_WORD},
			'{CH_LOWER_A, 1'b0, NO_WORD},
			'{CH_0, 1'b0, NO_WORD},
			'{CH_LF, 1'b1, word_of(8'h00, 1'b0, 1'b1, ST_FORMAT, 8'd0)},
			'{CH_COLON, 1'b0, NO_WORD},
			'{CH_LF, 1'b1, word_of(8'h00, 1'b0, 1'b1, ST_SHORT, 8'd0)},
			// A colon in mid-byte restarts the frame; the sum then misses by one.
			'{CH_COLON, 1'b0, NO_WORD},
			'{hex_char(4'h1), 1'b0, NO_WORD},
			'{CH_COLON, 1'b0, NO_WORD},
			'{CH_0, 1'b0, NO_WORD},
			'{CH_0, 1'b0, NO_WORD},
			'{CH_0, 1'b0, NO_WORD},
			'{CH_0, 1'b0, NO_WORD},
			'{CH_0, 1'b0, NO_WORD},
			'{hex_char(4'h1), 1'b0, NO_WORD},
			'{CH_LF, 1'b1, word_of(8'h00, 1'b0, 1'b1, ST_LRC, 8'd0)}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_rows[i])
			put_char(dir_rows[i].ch, dir_rows[i].fixed, dir_rows[i].want);
		// The first two frames sit right at and just past the length limit.
		frame_no = 0;
		while (items_used < ITEM_TARGET) begin
			if ($urandom_range(0, 1))
				repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(0, 255)));
			if (frame_no == 0)
				pdu_n = MAX_BYTES - 2;
			else if (frame_no == 1)
				pdu_n = MAX_BYTES - 1;
			else if ($urandom_range(0, 99) < 3)
				pdu_n = $urandom_range(MAX_BYTES - 6, MAX_BYTES + 2);
			else
				pdu_n = $urandom_range(0, 10);
			send_frame(pdu_n);
			frame_no++;
		end
		chr_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
